>>> hw/rtl/bte_pkg.sv
// ----------------------------------------------------------------------------
// bte_pkg: shared types and constants of the byte to text stream encoder
// Holds the payload structs, the mode codes and the character mapping helpers.
// ----------------------------------------------------------------------------
package bte_pkg;

	localparam logic [1:0] MODE_LATIN1 = 2'd0;
	localparam logic [1:0] MODE_HEX    = 2'd1;
	localparam logic [1:0] MODE_B64    = 2'd2;

	localparam logic [7:0] CHAR_PAD = 8'h3D;

	localparam int unsigned MAX_CHARS = 4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       flush;
	} data_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       last;
	} text_t;

	typedef logic [MAX_CHARS-1:0][7:0] group_t;

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		logic [7:0] w;
		w = {4'h0, v};
		if (v < 4'd10) begin
			return 8'h30 + w;
		end
		return 8'h61 + w - 8'd10;
	endfunction

	function automatic logic [7:0] b64_char(input logic [5:0] v);
		logic [7:0] w;
		w = {2'b00, v};
		if (v < 6'd26) begin
			return 8'h41 + w;
		end
		if (v < 6'd52) begin
			return 8'h61 + w - 8'd26;
		end
		if (v < 6'd62) begin
			return 8'h30 + w - 8'd52;
		end
		if (v == 6'd62) begin
			return 8'h2B;
		end
		return 8'h2F;
	endfunction

	// Encodes k bytes (1 to 3) into four characters; missing ones become padding.
	// Bytes beyond k must be passed in as zero.
	function automatic group_t b64_group(input logic [7:0] b0, input logic [7:0] b1,
			input logic [7:0] b2, input logic [1:0] k);
		group_t g;
		g[0] = b64_char(b0[7:2]);
		g[1] = b64_char({b0[1:0], b1[7:4]});
		g[2] = (k >= 2'd2) ? b64_char({b1[3:0], b2[7:6]}) : CHAR_PAD;
		g[3] = (k == 2'd3) ? b64_char(b2[5:0]) : CHAR_PAD;
		return g;
	endfunction

endpackage

>>> hw/rtl/byte_to_text_stream_encoder.sv
// ----------------------------------------------------------------------------
// byte_to_text_stream_encoder
// Turns a byte stream into Latin-1 UTF-8 bytes, hex digits or padded base64.
// ----------------------------------------------------------------------------
// Path: an accepted byte is held in the input register, then its characters
// go to the output buffer once it is free. Throughput: one item per cycle
// while the output is not stalled and each item makes no or one character;
// after one with more (up to four), the next waits in the input register until
// the output buffer, which hands out one character per beat, has emptied.
// Reset: clears the mode to Latin-1, the base64 byte count and all valid flags.
module byte_to_text_stream_encoder (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           mode_we,
	input  logic [1:0]     mode_wdata,
	input  logic           data_valid,
	output logic           data_ready,
	input  bte_pkg::data_t data,
	output logic           text_valid,
	input  logic           text_ready,
	output bte_pkg::text_t text
);
	import bte_pkg::*;

	logic [1:0] mode_q;

	logic  valid_s1;
	data_t item_s1;

	logic [7:0] pend0_q;
	logic [7:0] pend1_q;
	logic [1:0] pcnt_q;

	group_t     chars_q;
	logic [2:0] cnt_q;
	logic [1:0] idx_q;
	logic       busy_q;

	group_t     res_chars;
	logic [2:0] res_n;
	logic [7:0] pend0_d;
	logic [7:0] pend1_d;
	logic [1:0] pcnt_d;

	logic last_beat;
	logic buf_free;
	logic load;

	assign last_beat  = ({1'b0, idx_q} == (cnt_q - 3'd1));
	assign buf_free   = !busy_q || (text_ready && last_beat);
	assign load       = valid_s1 && buf_free;
	assign data_ready = !valid_s1 || buf_free;

	assign text_valid    = busy_q;
	assign text.out_char = chars_q[idx_q];
	assign text.last     = last_beat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_LATIN1;
		end else if (mode_we) begin
			mode_q <= mode_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (data_ready) begin
			valid_s1 <= data_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (data_ready && data_valid) begin
			item_s1 <= data;
		end
	end

	// Result of the item in the input register, and the base64 state it leaves.
	always_comb begin
		res_chars = '0;
		res_n     = 3'd0;
		pend0_d   = pend0_q;
		pend1_d   = pend1_q;
		pcnt_d    = pcnt_q;
		case (mode_q)
			MODE_LATIN1: begin
				if (item_s1.byte_valid) begin
					if (!item_s1.data_byte[7]) begin
						res_chars[0] = item_s1.data_byte;
						res_n        = 3'd1;
					end else begin
						res_chars[0] = {6'b110000, item_s1.data_byte[7:6]};
						res_chars[1] = {2'b10, item_s1.data_byte[5:0]};
						res_n        = 3'd2;
					end
				end
			end
			MODE_HEX: begin
				if (item_s1.byte_valid) begin
					res_chars[0] = hex_char(item_s1.data_byte[7:4]);
					res_chars[1] = hex_char(item_s1.data_byte[3:0]);
					res_n        = 3'd2;
				end
			end
			MODE_B64: begin
				if (item_s1.byte_valid) begin
					if (pcnt_q[1]) begin
						res_chars = b64_group(pend0_q, pend1_q, item_s1.data_byte, 2'd3);
						res_n     = 3'd4;
						pcnt_d    = 2'd0;
					end else begin
						if (pcnt_q[0]) begin
							pend1_d = item_s1.data_byte;
						end else begin
							pend0_d = item_s1.data_byte;
						end
						pcnt_d = pcnt_q + 2'd1;
					end
				end
				// A flush after a completed group finds nothing held and adds nothing.
				if (item_s1.flush && (pcnt_d != 2'd0)) begin
					if (pcnt_d == 2'd1) begin
						res_chars = b64_group(pend0_d, 8'h00, 8'h00, 2'd1);
					end else begin
						res_chars = b64_group(pend0_d, pend1_d, 8'h00, 2'd2);
					end
					res_n  = 3'd4;
					pcnt_d = 2'd0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcnt_q <= 2'd0;
		end else if (load) begin
			pcnt_q <= pcnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pend0_q <= pend0_d;
			pend1_q <= pend1_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= 3'd0;
			idx_q  <= 2'd0;
		end else if (load) begin
			busy_q <= (res_n != 3'd0);
			cnt_q  <= res_n;
			idx_q  <= 2'd0;
		end else if (busy_q && text_ready) begin
			if (last_beat) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			chars_q <= res_chars;
		end
	end

	a_pcnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		pcnt_q != 2'd3)
		else $error("base64 byte count out of range");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (cnt_q != 3'd0 && cnt_q <= 3'd4))
		else $error("output buffer holds an invalid character count");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		(load && res_n != 3'd0) |=> (text_valid && idx_q == 2'd0))
		else $error("loaded result not presented from its first character");

	a_b64_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(load && mode_q == MODE_B64 && item_s1.flush) |=> (pcnt_q == 2'd0))
		else $error("base64 flush left bytes held");

	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !(text_ready && last_beat)) |-> !load)
		else $error("result buffer overwritten before its last beat");

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: byte to text stream encoder testbench
// Sends byte beats in the Latin-1, hex, base64 and unused modes with random
// gaps and output stalls. Every character that comes out is checked against a
// predicted character stream.
// ----------------------------------------------------------------------------

class text_board;
	logic [1:0]       mode;
	logic [7:0]       held [2];
	logic [1:0]       held_cnt;
	logic [7:0]       fresh [$];
	bte_pkg::text_t   chars_due [$];
	int               errors;
	string            hex_alpha;
	string            b64_alpha;

	function new();
		mode      = bte_pkg::MODE_LATIN1;
		held[0]   = 8'h00;
		held[1]   = 8'h00;
		held_cnt  = 2'd0;
		errors    = 0;
		hex_alpha = "0123456789abcdef";
		b64_alpha = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
	endfunction

	// Appends four base64 characters for k real bytes; the rest become padding.
	function void add_group(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2, int k);
		logic [5:0] s0;
		logic [5:0] s1;
		logic [5:0] s2;
		logic [5:0] s3;
		s0 = b0[7:2];
		s1 = {b0[1:0], b1[7:4]};
		s2 = {b1[3:0], b2[7:6]};
		s3 = b2[5:0];
		fresh.push_back(b64_alpha[s0]);
		fresh.push_back(b64_alpha[s1]);
		fresh.push_back(k >= 2 ? b64_alpha[s2] : bte_pkg::CHAR_PAD);
		fresh.push_back(k == 3 ? b64_alpha[s3] : bte_pkg::CHAR_PAD);
	endfunction

	function void take_item(bte_pkg::data_t d);
		bte_pkg::text_t t;
		fresh.delete();
		case (mode)
			bte_pkg::MODE_LATIN1: begin
				if (d.byte_valid) begin
					if (d.data_byte < 8'h80) begin
						fresh.push_back(d.data_byte);
					end else begin
						fresh.push_back(8'hC0 | {6'd0, d.data_byte[7:6]});
						fresh.push_back(8'h80 | {2'd0, d.data_byte[5:0]});
					end
				end
			end
			bte_pkg::MODE_HEX: begin
				if (d.byte_valid) begin
					fresh.push_back(hex_alpha[d.data_byte[7:4]]);
					fresh.push_back(hex_alpha[d.data_byte[3:0]]);
				end
			end
			bte_pkg::MODE_B64: begin
				if (d.byte_valid) begin
					if (held_cnt == 2'd2) begin
						add_group(held[0], held[1], d.data_byte, 3);
						held_cnt = 2'd0;
					end else begin
						held[held_cnt[0]] = d.data_byte;
						held_cnt = held_cnt + 2'd1;
					end
				end
				// The byte goes in first, so a flush may find the group already closed.
				if (d.flush && held_cnt != 2'd0) begin
					if (held_cnt == 2'd1) begin
						add_group(held[0], 8'h00, 8'h00, 1);
					end else begin
						add_group(held[0], held[1], 8'h00, 2);
					end
					held_cnt = 2'd0;
				end
			end
			default: begin
			end
		endcase
		foreach (fresh[i]) begin
			t.out_char = fresh[i];
			t.last     = (i == fresh.size() - 1);
			chars_due.push_back(t);
		end
	endfunction

	function void check_char(bte_pkg::text_t got);
		bte_pkg::text_t want;
		if (chars_due.size() == 0) begin
			$error("character %h with last %b came with none expected", got.out_char, got.last);
			errors++;
			return;
		end
		want = chars_due.pop_front();
		if (got.out_char !== want.out_char) begin
			$error("out_char: expected %h, got %h", want.out_char, got.out_char);
			errors++;
		end
		if (got.last !== want.last) begin
			$error("last: expected %b, got %b", want.last, got.last);
			errors++;
		end
	endfunction
endclass

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] MODE_UNUSED   = 2'd3;
	localparam int         SETTLE_CYCLES = 8;
	localparam int         CYCLE_LIMIT   = 400000;
	localparam int         RANDOM_PHASES = 14;
	localparam int         PHASE_ITEMS   = 34;

	logic           clk        = 1'b0;
	logic           arst_n     = 1'b0;
	logic           mode_we    = 1'b0;
	logic [1:0]     mode_wdata = 2'd0;
	logic           data_valid = 1'b0;
	logic           data_ready;
	bte_pkg::data_t data       = '0;
	logic           text_valid;
	logic           text_ready = 1'b0;
	bte_pkg::text_t text;

	text_board board;
	bit        no_gaps   = 1'b0;
	int        cycle_cnt = 0;

	byte_to_text_stream_encoder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.mode_we    (mode_we),
		.mode_wdata (mode_wdata),
		.data_valid (data_valid),
		.data_ready (data_ready),
		.data       (data),
		.text_valid (text_valid),
		.text_ready (text_ready),
		.text       (text)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
	end

	initial begin
		wait (cycle_cnt == CYCLE_LIMIT);
		$display("byte_to_text_stream_encoder test failed");
		$finish;
	end

	function automatic bte_pkg::data_t make_beat(logic [7:0] b, logic v, logic f);
		bte_pkg::data_t d;
		d.data_byte  = b;
		d.byte_valid = v;
		d.flush      = f;
		return d;
	endfunction

	function automatic bte_pkg::data_t random_beat(logic [1:0] m);
		logic [7:0] b;
		logic       v;
		logic       f;
		case ($urandom_range(0, 11))
			0:       b = 8'h00;
			1:       b = 8'hFF;
			2:       b = 8'h7F;
			3:       b = 8'h80;
			default: b = 8'($urandom_range(0, 255));
		endcase
		v = ($urandom_range(0, 9) != 0);
		// Base64 streams get frequent flushes so that every pending count is closed out.
		if (m == bte_pkg::MODE_B64) begin
			f = ($urandom_range(0, 4) == 0);
		end else begin
			f = ($urandom_range(0, 9) == 0);
		end
		return make_beat(b, v, f);
	endfunction

	task automatic send_beat(bte_pkg::data_t d);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			data_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		data       <= d;
		data_valid <= 1'b1;
		do @(posedge clk); while (!data_ready);
		board.take_item(d);
	endtask

	// Holds the input off until every expected character is out, then lets the
	// pipeline settle in case the last beats produced nothing.
	task automatic drain();
		data_valid <= 1'b0;
		while (board.chars_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode(logic [1:0] m);
		mode_we    <= 1'b1;
		mode_wdata <= m;
		@(posedge clk);
		mode_we    <= 1'b0;
		board.mode = m;
	endtask

	initial begin
		int stall;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = no_gaps ? 0 : $urandom_range(0, 17);
			if (stall > 0) begin
				text_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			text_ready <= 1'b1;
			do @(posedge clk); while (!text_valid);
			board.check_char(text);
		end
	end

	initial begin
		logic [1:0] m;
		int         n;
		board = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Latin-1 straight out of reset: both sides of the two-byte boundary.
		send_beat(make_beat(8'h00, 1'b1, 1'b0));
		send_beat(make_beat(8'h7F, 1'b1, 1'b0));
		send_beat(make_beat(8'h80, 1'b1, 1'b0));
		send_beat(make_beat(8'hFF, 1'b1, 1'b0));
		send_beat(make_beat(8'hAA, 1'b0, 1'b0));
		send_beat(make_beat(8'h41, 1'b1, 1'b1));
		drain();

		write_mode(bte_pkg::MODE_HEX);
		send_beat(make_beat(8'h00, 1'b1, 1'b0));
		send_beat(make_beat(8'hFF, 1'b1, 1'b0));
		send_beat(make_beat(8'h9C, 1'b1, 1'b1));
		send_beat(make_beat(8'h00, 1'b0, 1'b1));
		drain();

		write_mode(bte_pkg::MODE_B64);
		send_beat(make_beat(8'h00, 1'b0, 1'b1));
		send_beat(make_beat(8'h00, 1'b1, 1'b0));
		send_beat(make_beat(8'h00, 1'b1, 1'b0));
		send_beat(make_beat(8'h00, 1'b1, 1'b0));
		send_beat(make_beat(8'hFF, 1'b1, 1'b0));
		send_beat(make_beat(8'hFF, 1'b1, 1'b0));
		send_beat(make_beat(8'hFF, 1'b1, 1'b1));
		send_beat(make_beat(8'h4D, 1'b1, 1'b0));
		send_beat(make_beat(8'h00, 1'b0, 1'b1));
		send_beat(make_beat(8'h4D, 1'b1, 1'b0));
		send_beat(make_beat(8'h61, 1'b1, 1'b1));

		// A held base64 byte has to survive hex and unused-mode traffic.
		send_beat(make_beat(8'hAB, 1'b1, 1'b0));
		drain();
		write_mode(bte_pkg::MODE_HEX);
		send_beat(make_beat(8'h10, 1'b1, 1'b1));
		drain();
		write_mode(MODE_UNUSED);
		send_beat(make_beat(8'hFF, 1'b1, 1'b1));
		send_beat(make_beat(8'h00, 1'b0, 1'b1));
		drain();
		write_mode(bte_pkg::MODE_B64);
		send_beat(make_beat(8'hCD, 1'b1, 1'b1));

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			drain();
			if (ph < 4) begin
				m = 2'(ph);
			end else if ($urandom_range(0, 9) == 0) begin
				m = MODE_UNUSED;
			end else begin
				m = 2'($urandom_range(0, 2));
			end
			write_mode(m);
			no_gaps = ($urandom_range(0, 3) == 0);
			n = (m == MODE_UNUSED) ? 6 : PHASE_ITEMS;
			for (int i = 0; i < n; i++) begin
				send_beat(random_beat(m));
				if ($urandom_range(0, 39) == 0) begin
					drain();
				end
			end
		end
		no_gaps = 1'b0;
		drain();

		if (board.errors == 0 && board.chars_due.size() == 0) begin
			$display("byte_to_text_stream_encoder test passed");
		end else begin
			$display("byte_to_text_stream_encoder test failed");
		end
		$finish;
	end

endmodule
